// ----- design/cpt_pkg.sv -----
// shared types and constants for the cursor position tracker
package cpt_pkg;

    // stream payload widths, padded to whole bytes
    localparam int InDataW  = 88;
    localparam int OutDataW = 104;

    // register port
    localparam int CfgAddrW = 5;
    localparam int CfgDataW = 32;

    // register indexes (byte address is 4 times the index)
    localparam logic [2:0] REG_DEVICE_ID    = 3'd0;
    localparam logic [2:0] REG_BOUND_LEFT   = 3'd1;
    localparam logic [2:0] REG_BOUND_TOP    = 3'd2;
    localparam logic [2:0] REG_BOUND_RIGHT  = 3'd3;
    localparam logic [2:0] REG_BOUND_BOTTOM = 3'd4;
    localparam logic [2:0] REG_HOTSPOT_X    = 3'd5;
    localparam logic [2:0] REG_HOTSPOT_Y    = 3'd6;

    // configuration seen by the datapath
    typedef struct packed {
        logic [15:0]        device_id;
        logic signed [15:0] bound_left;
        logic signed [15:0] bound_top;
        logic signed [15:0] bound_right;
        logic signed [15:0] bound_bottom;
        logic signed [15:0] hotspot_x;
        logic signed [15:0] hotspot_y;
    } cfg_t;

    // one pointer report
    typedef struct packed {
        logic [15:0]        source_id;
        logic               is_mouse;
        logic [15:0]        move_mode;
        logic signed [16:0] coord_x;
        logic signed [16:0] coord_y;
        logic [15:0]        button_flags;
    } item_t;

    // one result item
    typedef struct packed {
        logic               accepted;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [16:0] delta_x;
        logic signed [16:0] delta_y;
        logic signed [16:0] window_x;
        logic signed [16:0] window_y;
        logic [2:0]         buttons_held;
    } result_t;

endpackage

// ----- design/cpt_regs.sv -----
// register file behind the configuration port
module cpt_regs
    import cpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready,
    output cfg_t                cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[4:2];
    assign cfg     = cfg_reg;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_DEVICE_ID:    cfg_reg.device_id    <= pwdata[15:0];
                REG_BOUND_LEFT:   cfg_reg.bound_left   <= pwdata[15:0];
                REG_BOUND_TOP:    cfg_reg.bound_top    <= pwdata[15:0];
                REG_BOUND_RIGHT:  cfg_reg.bound_right  <= pwdata[15:0];
                REG_BOUND_BOTTOM: cfg_reg.bound_bottom <= pwdata[15:0];
                REG_HOTSPOT_X:    cfg_reg.hotspot_x    <= pwdata[15:0];
                REG_HOTSPOT_Y:    cfg_reg.hotspot_y    <= pwdata[15:0];
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        case (reg_idx)
            REG_DEVICE_ID:    prdata = {16'd0, cfg_reg.device_id};
            REG_BOUND_LEFT:   prdata = {16'd0, cfg_reg.bound_left};
            REG_BOUND_TOP:    prdata = {16'd0, cfg_reg.bound_top};
            REG_BOUND_RIGHT:  prdata = {16'd0, cfg_reg.bound_right};
            REG_BOUND_BOTTOM: prdata = {16'd0, cfg_reg.bound_bottom};
            REG_HOTSPOT_X:    prdata = {16'd0, cfg_reg.hotspot_x};
            REG_HOTSPOT_Y:    prdata = {16'd0, cfg_reg.hotspot_y};
            default:          prdata = '0;
        endcase
    end

endmodule

// ----- design/cpt_in_stage.sv -----
// input register stage for pointer reports
module cpt_in_stage
    import cpt_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  item_t in_item,
    output logic  item_valid,
    input  logic  item_take,
    output item_t item
);

    logic  valid_reg;
    item_t item_reg;

    // room when empty or when the held item moves on this cycle
    assign in_ready   = !valid_reg || item_take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

endmodule

// ----- design/cpt_update.sv -----
// cursor state update, clamp, button decode and result register
module cpt_update
    import cpt_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  logic    item_valid,
    output logic    item_take,
    input  item_t   item,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t result
);

    // button indexes in the held state
    localparam int BtnLeft   = 0;
    localparam int BtnMiddle = 1;
    localparam int BtnRight  = 2;
    // flag bits of a report
    localparam int FlagLeftDown   = 0;
    localparam int FlagLeftUp     = 1;
    localparam int FlagRightDown  = 2;
    localparam int FlagRightUp    = 3;
    localparam int FlagMiddleDown = 4;
    localparam int FlagMiddleUp   = 5;

    logic signed [15:0] cursor_x_reg, cursor_x_next;
    logic signed [15:0] cursor_y_reg, cursor_y_next;
    logic signed [16:0] delta_x_reg, delta_x_next;
    logic signed [16:0] delta_y_reg, delta_y_next;
    logic [2:0]         buttons_reg, buttons_next;
    logic               out_valid_reg;
    result_t            result_reg, result_next;

    logic               fire;
    logic               match;
    logic               rel_move;
    logic               abs_move;
    logic signed [17:0] target_x;
    logic signed [17:0] target_y;
    logic signed [15:0] clamp_x;
    logic signed [15:0] clamp_y;

    // raise to the low bound, then lower to the high bound
    function automatic logic signed [15:0] clamp(
        input logic signed [17:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [17:0] lo_ext;
        logic signed [17:0] hi_ext;
        logic signed [17:0] t;
        begin
            lo_ext = {{2{lo[15]}}, lo};
            hi_ext = {{2{hi[15]}}, hi};
            t = (v < lo_ext) ? lo_ext : v;
            t = (t > hi_ext) ? hi_ext : t;
            clamp = t[15:0];
        end
    endfunction

    // up events beat down events; right beats middle beats left
    function automatic logic [2:0] next_held(
        input logic [2:0]  held,
        input logic [15:0] f
    );
        logic [2:0] b;
        begin
            b = held;
            if (f[FlagRightUp])
                b[BtnRight] = 1'b0;
            else if (f[FlagMiddleUp])
                b[BtnMiddle] = 1'b0;
            else if (f[FlagLeftUp])
                b[BtnLeft] = 1'b0;
            else if (f[FlagRightDown])
                b[BtnRight] = 1'b1;
            else if (f[FlagMiddleDown])
                b[BtnMiddle] = 1'b1;
            else if (f[FlagLeftDown])
                b[BtnLeft] = 1'b1;
            next_held = b;
        end
    endfunction

    assign item_take = !out_valid_reg || out_ready;
    assign fire      = item_valid && item_take;
    assign out_valid = out_valid_reg;
    assign result    = result_reg;

    // report filter and move kind
    assign match    = item.is_mouse && (item.source_id == cfg.device_id);
    assign rel_move = (item.move_mode == 16'd0);
    assign abs_move = item.move_mode[0];

    // target position, relative or absolute
    always_comb
    begin
        if (rel_move)
        begin
            target_x = {{2{cursor_x_reg[15]}}, cursor_x_reg}
                     + {item.coord_x[16], item.coord_x};
            target_y = {{2{cursor_y_reg[15]}}, cursor_y_reg}
                     + {item.coord_y[16], item.coord_y};
        end
        else
        begin
            target_x = {item.coord_x[16], item.coord_x};
            target_y = {item.coord_y[16], item.coord_y};
        end
    end

    assign clamp_x = clamp(target_x, cfg.bound_left, cfg.bound_right);
    assign clamp_y = clamp(target_y, cfg.bound_top, cfg.bound_bottom);

    // next state
    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        delta_x_next  = delta_x_reg;
        delta_y_next  = delta_y_reg;
        buttons_next  = buttons_reg;
        if (match)
        begin
            if (rel_move || abs_move)
            begin
                cursor_x_next = clamp_x;
                cursor_y_next = clamp_y;
                delta_x_next  = {clamp_x[15], clamp_x} - {cursor_x_reg[15], cursor_x_reg};
                delta_y_next  = {clamp_y[15], clamp_y} - {cursor_y_reg[15], cursor_y_reg};
            end
            else
            begin
                delta_x_next = '0;
                delta_y_next = '0;
            end
            buttons_next = next_held(buttons_reg, item.button_flags);
        end
    end

    // result from the updated state
    always_comb
    begin
        result_next.accepted     = match;
        result_next.pos_x        = cursor_x_next;
        result_next.pos_y        = cursor_y_next;
        result_next.delta_x      = delta_x_next;
        result_next.delta_y      = delta_y_next;
        result_next.window_x     = {cursor_x_next[15], cursor_x_next}
                                 - {cfg.hotspot_x[15], cfg.hotspot_x};
        result_next.window_y     = {cursor_y_next[15], cursor_y_next}
                                 - {cfg.hotspot_y[15], cfg.hotspot_y};
        result_next.buttons_held = buttons_next;
    end

    // cursor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg <= '0;
            cursor_y_reg <= '0;
            delta_x_reg  <= '0;
            delta_y_reg  <= '0;
            buttons_reg  <= '0;
        end
        else if (fire)
        begin
            cursor_x_reg <= cursor_x_next;
            cursor_y_reg <= cursor_y_next;
            delta_x_reg  <= delta_x_next;
            delta_y_reg  <= delta_y_next;
            buttons_reg  <= buttons_next;
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            out_valid_reg <= item_valid;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result_next;
        end
    end

endmodule

// ----- design/cursor_position_tracker.sv -----
// top level of the cursor position tracker
// Tracks a pointer cursor from raw mouse reports: one report enters per clock unless
// the result side stalls, and its result passes the input and result registers. The
// rate is set by the single update stage, where the cursor, delta and button registers
// feed back into the clamp and button decode for the next report. Reports from another
// device id or that are not mouse reports leave the state as it is and still produce a
// result with the accepted flag clear. The user must write bounds, device id and
// hotspot via the register port with no report in flight; the block does not enforce it.
module cursor_position_tracker
    import cpt_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    // report stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // source_id[15:0], move_mode[31:16], coord_x[48:32], coord_y[65:49],
    // button_flags[81:66], zero pad[87:82]
    input  logic [InDataW-1:0]  s_tdata,
    // is_mouse[0]
    input  logic [0:0]          s_tuser,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // pos_x[15:0], pos_y[31:16], delta_x[48:32], delta_y[65:49], window_x[82:66],
    // window_y[99:83], buttons_held[102:100], zero pad[103]
    output logic [OutDataW-1:0] m_tdata,
    // accepted[0]
    output logic [0:0]          m_tuser,
    // register port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [CfgAddrW-1:0] paddr,
    input  logic [CfgDataW-1:0] pwdata,
    output logic [CfgDataW-1:0] prdata,
    output logic                pready
);

    cfg_t    cfg;
    item_t   in_item;
    item_t   item;
    logic    item_valid;
    logic    item_take;
    result_t result;

    // unpack the report
    assign in_item.source_id    = s_tdata[15:0];
    assign in_item.is_mouse     = s_tuser[0];
    assign in_item.move_mode    = s_tdata[31:16];
    assign in_item.coord_x      = s_tdata[48:32];
    assign in_item.coord_y      = s_tdata[65:49];
    assign in_item.button_flags = s_tdata[81:66];

    // pack the result
    assign m_tdata = {1'b0, result.buttons_held, result.window_y, result.window_x,
                      result.delta_y, result.delta_x, result.pos_y, result.pos_x};
    assign m_tuser = result.accepted;

    cpt_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    cpt_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item)
    );

    cpt_update u_update (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item_take  (item_take),
        .item       (item),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

endmodule

// ----- design/cpt_checker.sv -----
// port-level checks for the cursor position tracker
module cpt_checker
    import cpt_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic [0:0]          m_tuser
);

    logic out_hs;

    assign out_hs = m_tvalid && m_tready;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // with the result side empty the block always takes an item
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty result stage");

    // an accepted report's delta is the position change from the previous result
    a_delta_matches: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs && $past(out_hs) && m_tuser[0] |->
            m_tdata[48:32] == 17'({m_tdata[15], m_tdata[15:0]}
                                 - {$past(m_tdata[15]), $past(m_tdata[15:0])}) &&
            m_tdata[65:49] == 17'({m_tdata[31], m_tdata[31:16]}
                                 - {$past(m_tdata[31]), $past(m_tdata[31:16])}))
        else $error("delta does not match position change");

    // a rejected report leaves position, delta and buttons as they were
    a_reject_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_hs && $past(out_hs) && !m_tuser[0] |->
            m_tdata[65:0] == $past(m_tdata[65:0]) &&
            m_tdata[102:100] == $past(m_tdata[102:100]))
        else $error("rejected report changed the state");

endmodule

bind cursor_position_tracker cpt_checker u_cpt_checker (.*);

// ----- tb/cpt_tb_pkg.sv -----
// result checker with its own cursor tracker prediction for the testbench
package cpt_tb_pkg;
    import cpt_pkg::*;

    // move mode codes
    localparam logic [15:0] MODE_RELATIVE = 16'h0000;
    localparam int          MODE_ABS_BIT  = 0;

    // button flag bit positions
    localparam int FLAG_L_DOWN = 0;
    localparam int FLAG_L_UP   = 1;
    localparam int FLAG_R_DOWN = 2;
    localparam int FLAG_R_UP   = 3;
    localparam int FLAG_M_DOWN = 4;
    localparam int FLAG_M_UP   = 5;

    // bit of each button in the held mask
    localparam int BTN_LEFT   = 0;
    localparam int BTN_MIDDLE = 1;
    localparam int BTN_RIGHT  = 2;

    localparam int SHOWN_MISMATCHES = 10;

    class cursor_checker;
        // register copy
        logic [15:0] device_id;
        int          bound_left;
        int          bound_top;
        int          bound_right;
        int          bound_bottom;
        int          hotspot_x;
        int          hotspot_y;

        // tracked cursor state
        int          cur_x;
        int          cur_y;
        int          step_x;
        int          step_y;
        logic [2:0]  held;

        result_t     predicted_states[$];
        int          fail_count;

        function new();
            device_id    = '0;
            bound_left   = 0;
            bound_top    = 0;
            bound_right  = 0;
            bound_bottom = 0;
            hotspot_x    = 0;
            hotspot_y    = 0;
            cur_x        = 0;
            cur_y        = 0;
            step_x       = 0;
            step_y       = 0;
            held         = '0;
            fail_count   = 0;
        endfunction

        // register write as the block sees it, upper word bits dropped
        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                REG_DEVICE_ID:    device_id    = value[15:0];
                REG_BOUND_LEFT:   bound_left   = $signed(value[15:0]);
                REG_BOUND_TOP:    bound_top    = $signed(value[15:0]);
                REG_BOUND_RIGHT:  bound_right  = $signed(value[15:0]);
                REG_BOUND_BOTTOM: bound_bottom = $signed(value[15:0]);
                REG_HOTSPOT_X:    hotspot_x    = $signed(value[15:0]);
                REG_HOTSPOT_Y:    hotspot_y    = $signed(value[15:0]);
                default: ;
            endcase
        endfunction

        // clamp low bound first, then high bound, so high wins when inverted
        function void move_to(int nx, int ny);
            if (nx < bound_left)   nx = bound_left;
            if (ny < bound_top)    ny = bound_top;
            if (nx > bound_right)  nx = bound_right;
            if (ny > bound_bottom) ny = bound_bottom;
            step_x = nx - cur_x;
            step_y = ny - cur_y;
            cur_x  = nx;
            cur_y  = ny;
        endfunction

        // one button event: ups beat downs, right > middle > left
        function void apply_button_event(logic [15:0] flags);
            int   pick;
            logic press;
            pick  = -1;
            press = 1'b0;
            if (flags[FLAG_L_DOWN]) begin pick = BTN_LEFT;   press = 1'b1; end
            if (flags[FLAG_M_DOWN]) begin pick = BTN_MIDDLE; press = 1'b1; end
            if (flags[FLAG_R_DOWN]) begin pick = BTN_RIGHT;  press = 1'b1; end
            if (flags[FLAG_L_UP])   begin pick = BTN_LEFT;   press = 1'b0; end
            if (flags[FLAG_M_UP])   begin pick = BTN_MIDDLE; press = 1'b0; end
            if (flags[FLAG_R_UP])   begin pick = BTN_RIGHT;  press = 1'b0; end
            if (pick >= 0)
                held[pick] = press;
        endfunction

        // update the state for one accepted report and queue its result
        function void accept_report(item_t rpt);
            result_t r;
            int      cx;
            int      cy;
            logic    hit;
            cx  = rpt.coord_x;
            cy  = rpt.coord_y;
            hit = (rpt.source_id == device_id) && rpt.is_mouse;
            if (hit) begin
                if (rpt.move_mode == MODE_RELATIVE)
                    move_to(cur_x + cx, cur_y + cy);
                else if (rpt.move_mode[MODE_ABS_BIT])
                    move_to(cx, cy);
                else begin
                    step_x = 0;
                    step_y = 0;
                end
                apply_button_event(rpt.button_flags);
            end
            r.accepted     = hit;
            r.pos_x        = 16'(cur_x);
            r.pos_y        = 16'(cur_y);
            r.delta_x      = 17'(step_x);
            r.delta_y      = 17'(step_y);
            r.window_x     = 17'(cur_x - hotspot_x);
            r.window_y     = 17'(cur_y - hotspot_y);
            r.buttons_held = held;
            predicted_states.push_back(r);
        endfunction

        function void compare_field(string field, longint want, longint seen);
            if (want != seen) begin
                fail_count++;
                if (fail_count <= SHOWN_MISMATCHES)
                    $display("mismatch at %0t ns: %s expected %0d, got %0d",
                             $time, field, want, seen);
            end
        endfunction

        // compare one result item with the oldest prediction
        function void check_result(logic accepted, logic [OutDataW-1:0] data);
            result_t got;
            result_t want;
            got.accepted     = accepted;
            got.pos_x        = data[15:0];
            got.pos_y        = data[31:16];
            got.delta_x      = data[48:32];
            got.delta_y      = data[65:49];
            got.window_x     = data[82:66];
            got.window_y     = data[99:83];
            got.buttons_held = data[102:100];
            if (predicted_states.size() == 0) begin
                fail_count++;
                if (fail_count <= SHOWN_MISMATCHES)
                    $display("mismatch at %0t ns: result item with none expected", $time);
                return;
            end
            want = predicted_states.pop_front();
            compare_field("accepted", want.accepted, got.accepted);
            compare_field("pos_x", want.pos_x, got.pos_x);
            compare_field("pos_y", want.pos_y, got.pos_y);
            compare_field("delta_x", want.delta_x, got.delta_x);
            compare_field("delta_y", want.delta_y, got.delta_y);
            compare_field("window_x", want.window_x, got.window_x);
            compare_field("window_y", want.window_y, got.window_y);
            compare_field("buttons_held", want.buttons_held, got.buttons_held);
        endfunction

        function int pending();
            return predicted_states.size();
        endfunction
    endclass

endpackage

// ----- tb/tb_top.sv -----
// top level testbench of the cursor position tracker
module tb_top;
    import cpt_pkg::*;
    import cpt_tb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 172;
    localparam int PHASE_COUNT  = 8;

    logic                clk      = 1'b0;
    logic                rst_n    = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    // source_id[15:0], move_mode[31:16], coord_x[48:32], coord_y[65:49],
    // button_flags[81:66], zero pad[87:82]
    logic [InDataW-1:0]  s_tdata  = '0;
    // is_mouse[0]
    logic [0:0]          s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    // pos_x[15:0], pos_y[31:16], delta_x[48:32], delta_y[65:49], window_x[82:66],
    // window_y[99:83], buttons_held[102:100], zero pad[103]
    logic [OutDataW-1:0] m_tdata;
    // accepted[0]
    logic [0:0]          m_tuser;
    logic                psel     = 1'b0;
    logic                penable  = 1'b0;
    logic                pwrite   = 1'b0;
    logic [CfgAddrW-1:0] paddr    = '0;
    logic [CfgDataW-1:0] pwdata   = '0;
    logic [CfgDataW-1:0] prdata;
    logic                pready;

    cursor_checker sb;

    // idling percentages of the current phase
    int          send_idle_pct = 0;
    int          stall_pct     = 0;
    int          cycle_count   = 0;

    // current register settings, used to aim absolute moves
    logic [15:0] dev_sel = '0;
    int          lo_x = 0;
    int          hi_x = 0;
    int          lo_y = 0;
    int          hi_y = 0;

    cursor_position_tracker u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("** cursor_position_tracker: FAILED **");
            $finish;
        end
    end

    // receiver back-pressure
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // input item monitor, unpacked from the pins
    always @(posedge clk)
    begin
        item_t seen;
        if (rst_n && s_tvalid && s_tready) begin
            seen.source_id    = s_tdata[15:0];
            seen.is_mouse     = s_tuser[0];
            seen.move_mode    = s_tdata[31:16];
            seen.coord_x      = s_tdata[48:32];
            seen.coord_y      = s_tdata[65:49];
            seen.button_flags = s_tdata[81:66];
            sb.accept_report(seen);
        end
    end

    // result item monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tuser[0], m_tdata);
    end

    function automatic item_t make_report(logic [15:0] src, logic mouse, logic [15:0] mode,
                                          int cx, int cy, logic [15:0] flags);
        item_t it;
        it.source_id    = src;
        it.is_mouse     = mouse;
        it.move_mode    = mode;
        it.coord_x      = cx[16:0];
        it.coord_y      = cy[16:0];
        it.button_flags = flags;
        return it;
    endfunction

    // absolute target around the bounds, sometimes anywhere in range
    function automatic int coord_near(int a, int b);
        int lo;
        int hi;
        if ($urandom_range(0, 7) == 0)
            return int'($signed(17'($urandom)));
        lo = ((a < b) ? a : b) - 64;
        hi = ((a < b) ? b : a) + 64;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // mostly well-formed reports for the configured device, some noise
    function automatic item_t random_report();
        item_t       it;
        int          pick;
        int          cx;
        int          cy;
        logic [15:0] mode;
        logic [15:0] flags;
        logic [15:0] src;
        logic        mouse;
        src   = dev_sel;
        mouse = 1'b1;
        pick  = $urandom_range(0, 99);
        if (pick < 6)
            src = 16'($urandom);
        else if (pick < 9)
            src = dev_sel ^ (16'h0001 << $urandom_range(0, 15));
        else if (pick < 14) begin
            mouse = 1'b0;
            if ($urandom_range(0, 1) == 0)
                src = 16'($urandom);
        end

        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            mode = MODE_RELATIVE;
            if ($urandom_range(0, 7) == 0) begin
                cx = int'($signed(17'($urandom)));
                cy = int'($signed(17'($urandom)));
            end else begin
                cx = int'($urandom_range(0, 400)) - 200;
                cy = int'($urandom_range(0, 400)) - 200;
            end
        end else if (pick < 8) begin
            mode = 16'($urandom) | 16'h0001;
            cx   = coord_near(lo_x, hi_x);
            cy   = coord_near(lo_y, hi_y);
        end else begin
            mode = 16'($urandom) & 16'hFFFE;
            if (mode == MODE_RELATIVE)
                mode = 16'h0002;
            cx = int'($signed(17'($urandom)));
            cy = int'($signed(17'($urandom)));
        end

        pick = $urandom_range(0, 9);
        if (pick < 3)
            flags = '0;
        else if (pick < 5)
            flags = 16'($urandom);
        else if (pick < 7)
            flags = 16'h0001 << $urandom_range(0, 5);
        else
            flags = {10'b0, 6'($urandom)};
        it = make_report(src, mouse, mode, cx, cy, flags);
        return it;
    endfunction

    // present one report, with a random gap first; starts and ends at a falling edge
    task automatic send_report(input item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, it.button_flags, it.coord_y, it.coord_x,
                     it.move_mode, it.source_id};
        s_tuser  <= it.is_mouse;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // setup and access phases, then the bus goes idle before the next write
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
        logic [31:0] word;
        word    = {16'($urandom), value};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= word;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, word);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
    endtask

    // stop sending and wait until every result has been seen
    task automatic drain();
        s_tvalid <= 1'b0;
        @(negedge clk);
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic set_registers(input logic [15:0] dev, input int l, input int t,
                                 input int r, input int b, input int hx, input int hy);
        dev_sel = dev;
        lo_x    = l;
        hi_x    = r;
        lo_y    = t;
        hi_y    = b;
        write_reg(REG_DEVICE_ID, dev);
        write_reg(REG_BOUND_LEFT, 16'(l));
        write_reg(REG_BOUND_TOP, 16'(t));
        write_reg(REG_BOUND_RIGHT, 16'(r));
        write_reg(REG_BOUND_BOTTOM, 16'(b));
        write_reg(REG_HOTSPOT_X, 16'(hx));
        write_reg(REG_HOTSPOT_Y, 16'(hy));
    endtask

    // register setting for each random phase
    task automatic configure_phase(input int p);
        int l;
        int t;
        case (p)
            0: set_registers(16'($urandom), -32768, -32768, 32767, 32767,
                             int'($signed(16'($urandom))), int'($signed(16'($urandom))));
            1: begin
                l = int'($urandom_range(0, 200)) - 300;
                t = int'($urandom_range(0, 200)) - 300;
                set_registers(16'($urandom), l, t, l + int'($urandom_range(0, 300)),
                              t + int'($urandom_range(0, 300)), 32767, -32768);
            end
            // inverted bounds
            2: begin
                l = int'($urandom_range(0, 1000));
                t = int'($urandom_range(0, 1000));
                set_registers(16'($urandom), l, t, l - int'($urandom_range(1, 1000)),
                              t - int'($urandom_range(1, 1000)),
                              int'($urandom_range(0, 100)), -int'($urandom_range(0, 100)));
            end
            3: set_registers(16'h0000, 0, 0, 0, 0, 0, 0);
            4: set_registers(16'hFFFF, -32768, 32767 - int'($urandom_range(0, 50)),
                             -32768 + int'($urandom_range(0, 50)), 32767, -32768, 32767);
            default: set_registers(16'($urandom),
                                   int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                                   int'($signed(16'($urandom))), int'($signed(16'($urandom))),
                                   int'($signed(16'($urandom))), int'($signed(16'($urandom))));
        endcase
    endtask

    // main sequence
    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: device 0 and every bound at 0
        send_report(make_report(16'h0000, 1'b1, MODE_RELATIVE, 100, -100, 16'h0001));
        send_report(make_report(16'h0001, 1'b1, 16'h0001, 5, 5, 16'h0004));
        send_report(make_report(16'h0000, 1'b0, MODE_RELATIVE, 7, 7, 16'h0010));
        drain();

        // directed: widest bounds, hotspot extremes
        set_registers(16'hFFFF, -32768, -32768, 32767, 32767, -32768, 32767);
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 65535, 65535, 16'h0000));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, -65536, -65536, 16'h0000));
        send_report(make_report(16'hFFFF, 1'b1, 16'h0001, 0, 0, 16'h0000));
        send_report(make_report(16'hFFFF, 1'b1, 16'hFFFF, 65535, -65536, 16'h0000));
        // no movement modes zero the deltas
        send_report(make_report(16'hFFFF, 1'b1, 16'h0002, 123, 456, 16'h0000));
        send_report(make_report(16'hFFFF, 1'b1, 16'hFFFE, -9, 9, 16'h0000));
        // rejected by id, then by report type
        send_report(make_report(16'h0000, 1'b1, MODE_RELATIVE, 50, 50, 16'h0001));
        send_report(make_report(16'hFFFF, 1'b0, 16'h0001, 300, 300, 16'h0015));
        // single downs, then priority cases
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 5, -3, 16'h0001));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 0, 0, 16'h0010));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 0, 0, 16'h0004));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 0, 0, 16'h0006));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 0, 0, 16'h003F));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 0, 0, 16'h0022));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 0, 0, 16'h0015));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 0, 0, 16'h0011));
        // flag bits above the six events are ignored
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, 1, 1, 16'hFFC0));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, -1, -1, 16'hFFFF));
        send_report(make_report(16'hFFFF, 1'b1, 16'h8001, 32767, -32768, 16'h0001));
        send_report(make_report(16'hFFFF, 1'b1, MODE_RELATIVE, -65536, 65535, 16'h0000));
        drain();

        // random phases, each with its own setting and idling
        for (int p = 0; p < PHASE_COUNT; p++) begin
            case (p % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 81; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 81; end
                default: begin send_idle_pct = 22; stall_pct = 22; end
            endcase
            configure_phase(p);
            repeat (PHASE_ITEMS) send_report(random_report());
            drain();
        end

        repeat (8) @(negedge clk);
        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("** cursor_position_tracker: PASSED **");
        else
            $display("** cursor_position_tracker: FAILED **");
        $finish;
    end

endmodule

// ----- cursor_position_tracker.f -----
design/cpt_pkg.sv
design/cpt_regs.sv
design/cpt_in_stage.sv
design/cpt_update.sv
design/cursor_position_tracker.sv
design/cpt_checker.sv
tb/cpt_tb_pkg.sv
tb/tb_top.sv
